@@ rtl/core/sstoi_pkg.sv @@
package sstoi_pkg;

  localparam int CHAR_W      = 8;
  localparam int VALUE_W     = 64;
  localparam int OFFSET_W    = 12;
  localparam int BASE_W      = 6;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 6;
  localparam int MAC_W       = VALUE_W + BASE_W + 1;

  localparam int SHIFT_K = 10;
  localparam int SHIFT_M = 20;
  localparam int SHIFT_G = 30;

  localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_BASE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_MODE   = CFG_INDEX_W'(1);

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_DEC   = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_HEX   = BASE_W'(16);

  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UPPER_K = 8'h4B;
  localparam logic [CHAR_W-1:0] CH_LOWER_K = 8'h6B;
  localparam logic [CHAR_W-1:0] CH_UPPER_M = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_LOWER_M = 8'h6D;
  localparam logic [CHAR_W-1:0] CH_UPPER_G = 8'h47;
  localparam logic [CHAR_W-1:0] CH_LOWER_G = 8'h67;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_DIGITS = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_GARBAGE   = 2'd3
  } status_t;

  typedef enum logic {
    PH_DIGITS = 1'b0,
    PH_DONE   = 1'b1
  } phase_t;

  typedef struct packed {
    logic               ok;
    logic [BASE_W-1:0]  val;
  } digit_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    status_t             status;
    logic [OFFSET_W-1:0] offset;
  } result_t;

  function automatic digit_t digit_of(input logic [CHAR_W-1:0] c);
    digit_t d;
    d.ok  = 1'b0;
    d.val = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d.ok  = 1'b1;
      d.val = BASE_W'(c - CH_ZERO);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      d.ok  = 1'b1;
      d.val = BASE_W'(c - CH_LOWER_A) + BASE_W'(10);
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      d.ok  = 1'b1;
      d.val = BASE_W'(c - CH_UPPER_A) + BASE_W'(10);
    end
    return d;
  endfunction

endpackage

@@ rtl/core/sstoi_in_stage.sv @@
module sstoi_in_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          char_valid,
  input  logic [sstoi_pkg::CHAR_W-1:0]  char_code,
  output logic                          char_q_valid,
  output logic [sstoi_pkg::CHAR_W-1:0]  char_q
);
  import sstoi_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_q_valid <= 1'b0;
    end else if (advance) begin
      char_q_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      char_q <= char_code;
    end
  end

endmodule

@@ rtl/core/sstoi_parse.sv @@
module sstoi_parse (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  logic                               cfg_write,
  input  logic [sstoi_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sstoi_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               char_q_valid,
  input  logic [sstoi_pkg::CHAR_W-1:0]       char_q,
  output logic                               res_load,
  output sstoi_pkg::result_t                 res
);
  import sstoi_pkg::*;

  logic [BASE_W-1:0]   number_base;
  logic                size_mode;

  logic [VALUE_W-1:0]  acc, acc_next;
  phase_t              phase, phase_next;
  logic [OFFSET_W-1:0] pos, pos_next;
  logic                digit_seen, digit_seen_next;
  logic                lead_zero, lead_zero_next;
  status_t             err, err_next;
  logic [OFFSET_W-1:0] stop_off, stop_off_next;

  logic [BASE_W-1:0]   base;
  digit_t              dg;
  logic                is_nul;
  logic                dig_ok;
  logic                hex_skip;
  logic [MAC_W-1:0]    mac;
  logic                mac_ovf;
  logic                sfx_ok;
  logic                sfx_ovf;
  logic [VALUE_W-1:0]  scaled;
  logic [OFFSET_W-1:0] pos_inc;
  logic                stop_now;
  status_t             err_stop;
  logic                en;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_RESET;
      size_mode   <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_NUMBER_BASE: number_base <= cfg_data[BASE_W-1:0];
        CFG_SIZE_MODE:   size_mode   <= cfg_data[0];
      endcase
    end
  end

  assign base     = size_mode ? BASE_DEC : number_base;
  assign dg       = digit_of(char_q);
  assign is_nul   = (char_q == CH_NUL);
  assign dig_ok   = dg.ok && (dg.val < base);
  assign hex_skip = lead_zero && (base == BASE_HEX) && (char_q == CH_LOWER_X);
  assign mac      = MAC_W'(acc) * MAC_W'(base) + MAC_W'(dg.val);
  assign mac_ovf  = |mac[MAC_W-1:VALUE_W];
  assign pos_inc  = (pos == '1) ? pos : pos + OFFSET_W'(1);
  assign en       = char_q_valid && advance;

  // size suffix scaling
  always_comb begin
    sfx_ok  = 1'b0;
    sfx_ovf = 1'b0;
    scaled  = acc;
    case (char_q)
      CH_UPPER_G, CH_LOWER_G: begin
        sfx_ok  = 1'b1;
        sfx_ovf = |acc[VALUE_W-1 -: SHIFT_G];
        scaled  = acc << SHIFT_G;
      end
      CH_UPPER_M, CH_LOWER_M: begin
        sfx_ok  = 1'b1;
        sfx_ovf = |acc[VALUE_W-1 -: SHIFT_M];
        scaled  = acc << SHIFT_M;
      end
      CH_UPPER_K, CH_LOWER_K: begin
        sfx_ok  = 1'b1;
        sfx_ovf = |acc[VALUE_W-1 -: SHIFT_K];
        scaled  = acc << SHIFT_K;
      end
      default: ;
    endcase
  end

  // status once the digit run stops
  assign err_stop = (!digit_seen && err == ST_OK) ? ST_NO_DIGITS : err;

  always_comb begin
    phase_next = phase;
    if (is_nul) begin
      phase_next = PH_DIGITS;
    end else if (phase == PH_DIGITS && !hex_skip && (!dig_ok || mac_ovf)) begin
      phase_next = PH_DONE;
    end
  end

  always_comb begin
    acc_next        = acc;
    pos_next        = pos_inc;
    digit_seen_next = digit_seen;
    lead_zero_next  = lead_zero;
    err_next        = err;
    stop_off_next   = stop_off;
    stop_now        = (phase == PH_DIGITS);
    res.status      = stop_now ? err_stop : err;
    res.offset      = stop_now ? pos : stop_off;
    res.value       = (res.status == ST_OK) ? acc : '0;
    if (is_nul) begin
      acc_next        = '0;
      pos_next        = '0;
      digit_seen_next = 1'b0;
      lead_zero_next  = 1'b0;
      err_next        = ST_OK;
      stop_off_next   = '0;
    end else if (phase == PH_DIGITS) begin
      if (hex_skip) begin
        lead_zero_next  = 1'b0;
        digit_seen_next = 1'b0;
        acc_next        = '0;
      end else if (dig_ok) begin
        lead_zero_next = 1'b0;
        if (mac_ovf) begin
          if (err == ST_OK) err_next = ST_OVERFLOW;
          stop_off_next = pos;
        end else begin
          acc_next        = mac[VALUE_W-1:0];
          lead_zero_next  = (pos == '0) && (base == BASE_HEX) && (char_q == CH_ZERO);
          digit_seen_next = 1'b1;
        end
      end else begin
        lead_zero_next = 1'b0;
        stop_off_next  = pos;
        err_next       = err_stop;
        if (err_stop == ST_OK && size_mode) begin
          if (!sfx_ok) begin
            err_next = ST_GARBAGE;
          end else if (sfx_ovf) begin
            err_next = ST_OVERFLOW;
          end else begin
            acc_next = scaled;
          end
        end
      end
    end else if (size_mode && err == ST_OK) begin
      err_next = ST_GARBAGE;
    end
  end

  assign res_load = char_q_valid && is_nul;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      phase      <= PH_DIGITS;
      pos        <= '0;
      digit_seen <= 1'b0;
      lead_zero  <= 1'b0;
      err        <= ST_OK;
      stop_off   <= '0;
    end else if (en) begin
      acc        <= acc_next;
      phase      <= phase_next;
      pos        <= pos_next;
      digit_seen <= digit_seen_next;
      lead_zero  <= lead_zero_next;
      err        <= err_next;
      stop_off   <= stop_off_next;
    end
  end

endmodule

@@ rtl/core/sstoi_out_stage.sv @@
module sstoi_out_stage (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  logic                             res_load,
  input  sstoi_pkg::result_t               res,
  output logic                             result_valid,
  output logic [sstoi_pkg::VALUE_W-1:0]    result_value,
  output logic [1:0]                       parse_status,
  output logic [sstoi_pkg::OFFSET_W-1:0]   end_offset
);
  import sstoi_pkg::*;

  result_t res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_load) begin
      res_q <= res;
    end
  end

  assign result_value = res_q.value;
  assign parse_status = res_q.status;
  assign end_offset   = res_q.offset;

endmodule

@@ rtl/core/size_string_to_integer_parser.sv @@
// Size string parser: turns a zero-terminated byte string into a 64-bit value.
// Input channel: char_valid / char_stall with char_code, one byte per request;
// a zero byte ends the string. Output channel: result_valid / result_stall with
// result_value, parse_status and end_offset, one request per terminator.
// Configuration: cfg_write with cfg_index (0 number_base, 1 size_mode) and
// cfg_data; write only while no string is in flight.
// Throughput: one byte per cycle unless a waiting result holds the pipe, set by the
// multiply-add of the accumulator by the base between the input register and the state registers.
// Result path: the accepted terminator is captured in the input register, then the parse
// update loads the result into the result register.
// Stall: while a result waits under result_stall, the whole pipe holds and
// char_stall is raised; it drops the cycle the result is taken.
// Reset: clears both stages and the string state; number_base returns to 10
// and size_mode to 1.
module size_string_to_integer_parser (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [sstoi_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sstoi_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               char_valid,
  output logic                               char_stall,
  input  logic [sstoi_pkg::CHAR_W-1:0]       char_code,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [sstoi_pkg::VALUE_W-1:0]      result_value,
  output logic [1:0]                         parse_status,
  output logic [sstoi_pkg::OFFSET_W-1:0]     end_offset
);
  import sstoi_pkg::*;

  logic                advance;
  logic                char_q_valid;
  logic [CHAR_W-1:0]   char_q;
  logic                res_load;
  result_t             res;

  assign advance    = !(result_valid && result_stall);
  assign char_stall = !advance;

  sstoi_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .char_valid   (char_valid),
    .char_code    (char_code),
    .char_q_valid (char_q_valid),
    .char_q       (char_q)
  );

  sstoi_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .char_q_valid (char_q_valid),
    .char_q       (char_q),
    .res_load     (res_load),
    .res          (res)
  );

  sstoi_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .res_load     (res_load),
    .res          (res),
    .result_valid (result_valid),
    .result_value (result_value),
    .parse_status (parse_status),
    .end_offset   (end_offset)
  );

endmodule
